[sv/smooth_weighted_rr_select_macros.svh]
// Assertion macros for the smooth weighted round robin selector.
// Depends on nothing; the including module supplies clock and reset.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef SMOOTH_WEIGHTED_RR_SELECT_MACROS_SVH
`define SMOOTH_WEIGHTED_RR_SELECT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SWRR_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define SWRR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SWRR_ASSERT_IMPL(label, ante, cons, msg)
`define SWRR_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[sv/swrr_pkg.sv]
// Shared types, constants and helpers of the smooth weighted round robin selector.
// Depends on nothing; swrr_ctrl, swrr_datapath and the top import it, and the interfaces use its widths.
`timescale 1ns / 1ps

package swrr_pkg;

   localparam int MAX_NODES_DEFAULT = 16;

   localparam int OP_W     = 2;
   localparam int SLOT_W   = 4;
   localparam int WEIGHT_W = 8;
   localparam int STATUS_W = 2;
   localparam int FAIL_W   = 32;
   localparam int PCT_W    = 7;
   localparam int RW_W     = 24;

   localparam logic [PCT_W-1:0] PANIC_PCT_RESET = PCT_W'(20);
   localparam int PCT_SCALE = 100;

   localparam logic signed [RW_W+1:0] RUN_HI = (RW_W+2)'((2 ** (RW_W - 1)) - 1);
   localparam logic signed [RW_W+1:0] RUN_LO = (RW_W+2)'(-(2 ** (RW_W - 1)));

   typedef enum logic [OP_W-1:0] {
      OP_PICK   = 2'd0,
      OP_ADD    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_HEALTH = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      RSP_CHOSEN        = 2'd0,
      RSP_EMPTY         = 2'd1,
      RSP_NONE_ELIGIBLE = 2'd2,
      RSP_DONE          = 2'd3
   } rsp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_DECIDE,
      ST_WALK,
      ST_SETTLE,
      ST_EXEC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic count_step;
      logic decide;
      logic walk_step;
      logic settle;
      logic exec;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic req_pick;
      logic idx_last;
      logic empty;
      logic out_free;
   } stat_type;

   // Clamp a widened running weight back into the signed 24-bit range.
   function automatic logic signed [RW_W-1:0] sat_run(input logic signed [RW_W+1:0] v);
      logic signed [RW_W+1:0] c;
      if (v > RUN_HI) begin
         c = RUN_HI;
      end else if (v < RUN_LO) begin
         c = RUN_LO;
      end else begin
         c = v;
      end
      return c[RW_W-1:0];
   endfunction

endpackage

[sv/swrr_ifs.sv]
// Handshake channel interfaces of the selector: request, response and register write.
// Depends on swrr_pkg for the field widths.
`timescale 1ns / 1ps

interface swrr_req_if;
   logic                          valid;
   logic                          ready;
   logic [swrr_pkg::OP_W-1:0]     op;
   logic [swrr_pkg::SLOT_W-1:0]   slot;
   logic [swrr_pkg::WEIGHT_W-1:0] weight;
   logic                          alive;
   modport source (output valid, op, slot, weight, alive, input ready);
   modport sink (input valid, op, slot, weight, alive, output ready);
endinterface

interface swrr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [swrr_pkg::STATUS_W-1:0] status;
   logic [swrr_pkg::SLOT_W-1:0]   chosen_slot;
   logic                          panic;
   logic [swrr_pkg::FAIL_W-1:0]   failed_total;
   modport source (output valid, status, chosen_slot, panic, failed_total, input ready);
   modport sink (input valid, status, chosen_slot, panic, failed_total, output ready);
endinterface

interface swrr_csr_if;
   logic                       valid;
   logic                       ready;
   logic [swrr_pkg::PCT_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

[sv/swrr_ctrl.sv]
// Sequencing state machine of the selector: accepts a beat and steps the datapath.
// Depends on swrr_pkg for the state, command and status types.
`timescale 1ns / 1ps

module swrr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  swrr_pkg::stat_type stat,
   output swrr_pkg::cmd_type  cmd
);
   import swrr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = stat.req_pick ? ST_COUNT : ST_EXEC;
            end
         end
         ST_COUNT: begin
            cmd.count_step = 1'b1;
            if (stat.idx_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = stat.empty ? ST_FINISH : ST_WALK;
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (stat.idx_last) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            cmd.settle = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[sv/swrr_datapath.sv]
// Slot table, selection walk, failure counter and response register of the selector.
// Depends on swrr_pkg; driven by commands from swrr_ctrl.
`timescale 1ns / 1ps

module swrr_datapath #(
   parameter int MAX_NODES = swrr_pkg::MAX_NODES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  swrr_pkg::cmd_type             cmd,
   output swrr_pkg::stat_type            stat,
   input  logic [swrr_pkg::OP_W-1:0]     req_op,
   input  logic [swrr_pkg::SLOT_W-1:0]   req_slot,
   input  logic [swrr_pkg::WEIGHT_W-1:0] req_weight,
   input  logic                          req_alive,
   input  logic                          csr_write,
   input  logic [swrr_pkg::PCT_W-1:0]    csr_data,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [swrr_pkg::STATUS_W-1:0] rsp_status,
   output logic [swrr_pkg::SLOT_W-1:0]   rsp_chosen_slot,
   output logic                          rsp_panic,
   output logic [swrr_pkg::FAIL_W-1:0]   rsp_failed_total
);
   import swrr_pkg::*;

   localparam int IW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int TW = $clog2(MAX_NODES * 255 + 1);
   localparam int MW = CW + PCT_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_NODES - 1);

   // Slot table.
   logic [MAX_NODES-1:0]      present_ff;
   logic [MAX_NODES-1:0]      alive_ff;
   logic [WEIGHT_W-1:0]       weight_ff [MAX_NODES];
   logic signed [RW_W-1:0]    run_ff [MAX_NODES];

   // Captured request.
   op_type                    op_ff;
   logic [SLOT_W-1:0]         slot_ff;
   logic [WEIGHT_W-1:0]       wt_ff;
   logic                      alv_ff;

   // Walk state.
   logic [IW-1:0]             idx_ff, idx_in;
   logic [CW-1:0]             npres_ff;
   logic [CW-1:0]             nalive_ff;
   logic [TW-1:0]             total_ff;
   logic                      found_ff;
   logic [IW-1:0]             best_ff;
   logic signed [RW_W-1:0]    best_val_ff;
   logic                      panic_ff;
   rsp_status_type            res_status_ff;
   logic [SLOT_W-1:0]         res_chosen_ff;

   logic [FAIL_W-1:0]         failed_ff;
   logic [PCT_W-1:0]          pct_ff;

   logic                      rsp_valid_ff;
   rsp_status_type            rsp_status_ff;
   logic [SLOT_W-1:0]         rsp_chosen_ff;
   logic                      rsp_panic_ff;
   logic [FAIL_W-1:0]         rsp_failed_ff;

   logic                      cur_present, cur_alive, eligible, better, panic_now, slot_ok;
   logic [WEIGHT_W-1:0]       cur_w;
   logic signed [RW_W-1:0]    cur_run, grown;
   logic signed [RW_W+1:0]    grow_sum, reduce_sum;
   logic [MW-1:0]             alive_scaled, pct_scaled;
   logic [IW-1:0]             slot_idx;

   logic                      run_wr_en, wt_wr_en;
   logic [IW-1:0]             run_wr_idx;
   logic signed [RW_W-1:0]    run_wr_data;
   logic [WEIGHT_W-1:0]       wt_wr_data;

   assign cur_present = present_ff[idx_ff];
   assign cur_alive   = alive_ff[idx_ff];
   assign cur_w       = weight_ff[idx_ff];
   assign cur_run     = run_ff[idx_ff];

   assign grow_sum   = $signed({{2{cur_run[RW_W-1]}}, cur_run})
                     + $signed({{(RW_W + 2 - WEIGHT_W){1'b0}}, cur_w});
   assign grown      = sat_run(grow_sum);
   assign reduce_sum = $signed({{2{best_val_ff[RW_W-1]}}, best_val_ff})
                     - $signed({{(RW_W + 2 - TW){1'b0}}, total_ff});

   assign eligible = cur_present && (cur_alive || panic_ff);
   assign better   = !found_ff || (grown > best_val_ff);

   // floor(alive * 100 / present) < pct holds exactly when alive * 100 < pct * present.
   assign alive_scaled = MW'(nalive_ff) * MW'(PCT_SCALE);
   assign pct_scaled   = MW'(pct_ff) * MW'(npres_ff);
   assign panic_now    = alive_scaled < pct_scaled;

   assign slot_ok  = int'(slot_ff) < MAX_NODES;
   assign slot_idx = IW'(slot_ff);
   assign idx_in   = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;

   always_comb begin
      run_wr_en   = 1'b0;
      run_wr_idx  = slot_idx;
      run_wr_data = '0;
      wt_wr_en    = 1'b0;
      wt_wr_data  = '0;
      if (cmd.exec && slot_ok && (op_ff == OP_ADD || op_ff == OP_REMOVE)) begin
         run_wr_en  = 1'b1;
         wt_wr_en   = 1'b1;
         wt_wr_data = (op_ff == OP_ADD) ? wt_ff : '0;
      end else if (cmd.walk_step && eligible) begin
         run_wr_en   = 1'b1;
         run_wr_idx  = idx_ff;
         run_wr_data = grown;
      end else if (cmd.settle && found_ff) begin
         run_wr_en   = 1'b1;
         run_wr_idx  = best_ff;
         run_wr_data = sat_run(reduce_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (run_wr_en) begin
         run_ff[run_wr_idx] <= run_wr_data;
      end
      if (wt_wr_en) begin
         weight_ff[slot_idx] <= wt_wr_data;
      end
      if (cmd.accept) begin
         op_ff   <= op_type'(req_op);
         slot_ff <= req_slot;
         wt_ff   <= req_weight;
         alv_ff  <= req_alive;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_chosen_ff <= res_chosen_ff;
         rsp_panic_ff  <= panic_ff;
         rsp_failed_ff <= failed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff    <= '0;
         alive_ff      <= '0;
         failed_ff     <= '0;
         pct_ff        <= PANIC_PCT_RESET;
         rsp_valid_ff  <= 1'b0;
         idx_ff        <= '0;
         npres_ff      <= '0;
         nalive_ff     <= '0;
         total_ff      <= '0;
         found_ff      <= 1'b0;
         best_ff       <= '0;
         best_val_ff   <= '0;
         panic_ff      <= 1'b0;
         res_status_ff <= RSP_DONE;
         res_chosen_ff <= '0;
      end else begin
         if (csr_write) begin
            pct_ff <= csr_data;
         end

         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (cmd.accept) begin
            idx_ff        <= '0;
            npres_ff      <= '0;
            nalive_ff     <= '0;
            panic_ff      <= 1'b0;
            res_status_ff <= RSP_DONE;
            res_chosen_ff <= '0;
         end

         if (cmd.count_step) begin
            idx_ff    <= idx_in;
            npres_ff  <= npres_ff + CW'(cur_present);
            nalive_ff <= nalive_ff + CW'(cur_present && cur_alive);
         end

         if (cmd.decide) begin
            idx_ff   <= '0;
            total_ff <= '0;
            found_ff <= 1'b0;
            if (npres_ff == '0) begin
               res_status_ff <= RSP_EMPTY;
               if (failed_ff != '1) begin
                  failed_ff <= failed_ff + 1'b1;
               end
            end else begin
               panic_ff <= panic_now;
            end
         end

         if (cmd.walk_step) begin
            idx_ff <= idx_in;
            if (eligible) begin
               total_ff <= total_ff + TW'(cur_w);
               if (better) begin
                  found_ff    <= 1'b1;
                  best_ff     <= idx_ff;
                  best_val_ff <= grown;
               end
            end
         end

         if (cmd.settle) begin
            if (found_ff) begin
               res_status_ff <= RSP_CHOSEN;
               res_chosen_ff <= SLOT_W'(best_ff);
            end else begin
               res_status_ff <= RSP_NONE_ELIGIBLE;
            end
         end

         if (cmd.exec && slot_ok) begin
            case (op_ff)
               OP_ADD: begin
                  present_ff[slot_idx] <= 1'b1;
                  alive_ff[slot_idx]   <= alv_ff;
               end
               OP_REMOVE: begin
                  present_ff[slot_idx] <= 1'b0;
                  alive_ff[slot_idx]   <= 1'b0;
               end
               OP_HEALTH: begin
                  if (present_ff[slot_idx]) begin
                     alive_ff[slot_idx] <= alv_ff;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign stat.req_pick = (op_type'(req_op) == OP_PICK);
   assign stat.idx_last = (idx_ff == LAST_IDX);
   assign stat.empty    = (npres_ff == '0);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_chosen_slot  = rsp_chosen_ff;
   assign rsp_panic        = rsp_panic_ff;
   assign rsp_failed_total = rsp_failed_ff;

endmodule

[sv/smooth_weighted_rr_select.sv]
// Top level of the smooth weighted round robin server selector.
// Depends on swrr_pkg, the channel interfaces, swrr_ctrl, swrr_datapath and the macro header.
//
// Use: each request beat on req_chan carries an op (pick, add, remove, set health), a slot,
// a weight and an alive flag; every request produces exactly one response beat on rsp_chan
// with a status, the chosen slot, the panic flag and the saturating empty-table pick count.
// The panic percentage is written through csr_chan, which is always ready; write it only
// while no request is in flight.
// An add, remove or health beat runs the execute step, then loads its response. A pick walks
// the slot table twice, once to count present and alive slots and once to grow running
// weights and track the winner, one slot per cycle; on an empty table it skips the second
// walk. The table is read at one slot per cycle, and that single read port sets the rate:
// a new request is taken in the cycle after the previous response is loaded, so a pick or
// table update must finish before the next request is accepted.
// The response sits in an output register, so the next request is accepted while the
// previous response still waits; if the receiver stalls, the block finishes the next item
// and then holds it until the register frees up. Reset empties the table, clears the
// failure count, sets the panic percentage to 20 and drops any pending response.
`timescale 1ns / 1ps
`include "smooth_weighted_rr_select_macros.svh"

module smooth_weighted_rr_select #(
   parameter int MAX_NODES = swrr_pkg::MAX_NODES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   swrr_req_if.sink    req_chan,
   swrr_rsp_if.source  rsp_chan,
   swrr_csr_if.sink    csr_chan
);
   import swrr_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Short names for the conditions that the checks below look at.
   logic req_beat;
   logic rsp_panic_beat;
   logic rsp_chosen_beat;
   logic rsp_walked;
   logic chosen_in_table;

   // The register port never stalls.
   assign csr_chan.ready = 1'b1;

   swrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   swrr_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_op           (req_chan.op),
      .req_slot         (req_chan.slot),
      .req_weight       (req_chan.weight),
      .req_alive        (req_chan.alive),
      .csr_write        (csr_chan.valid),
      .csr_data         (csr_chan.data),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_status       (rsp_chan.status),
      .rsp_chosen_slot  (rsp_chan.chosen_slot),
      .rsp_panic        (rsp_chan.panic),
      .rsp_failed_total (rsp_chan.failed_total)
   );

   assign req_beat        = req_chan.valid && req_chan.ready;
   assign rsp_panic_beat  = rsp_chan.valid && rsp_chan.panic;
   assign rsp_chosen_beat = rsp_chan.valid && (rsp_chan.status == RSP_CHOSEN);
   assign rsp_walked      = (rsp_chan.status == RSP_CHOSEN)
                         || (rsp_chan.status == RSP_NONE_ELIGIBLE);
   assign chosen_in_table = int'(rsp_chan.chosen_slot) < MAX_NODES;

   // Once a beat is taken, the block is busy for at least the next cycle.
   `SWRR_ASSERT_NEXT(a_busy_after_accept, req_beat, !req_chan.ready, "request taken while busy")
   // The controller never loads a response over one that has not been taken.
   `SWRR_ASSERT_IMPL(a_no_overwrite, cmd.load_rsp, stat.out_free, "response overwritten")
   // Panic is only reported on a pick that reached the walk.
   `SWRR_ASSERT_IMPL(a_panic_on_pick, rsp_panic_beat, rsp_walked, "panic on a non-pick")
   // A chosen slot always lies inside the table.
   `SWRR_ASSERT_IMPL(a_chosen_in_range, rsp_chosen_beat, chosen_in_table, "slot out of range")

endmodule
